@@ hdl/keyed_record_table_unit_defines.svh @@
// Assertion macros shared by the keyed record table RTL.
`ifndef KEYED_RECORD_TABLE_UNIT_DEFINES_SVH
`define KEYED_RECORD_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define KRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define KRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/krt_pkg.sv @@
// Package with sizes, codes and record types of the keyed record table.
package krt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int IDX_W  = (SLOT_W > 4) ? SLOT_W : 4;
  localparam int KEY_W  = 16;

  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SET_A  = 3'd2,
    CMD_SET_B  = 3'd3,
    CMD_LOOKUP = 3'd4
  } krt_cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } krt_status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_COMMIT = 1'b1
  } krt_state_t;

  // Record payload, age in the low bits.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  grade_b;
    logic [6:0]  grade_a;
    logic [7:0]  sex;
    logic [6:0]  age;
  } krt_rec_t;

  // Write strobes broadcast to every cell; each cell applies them only if it won.
  typedef struct packed {
    logic wr_new;
    logic clr;
    logic set_a;
    logic set_b;
  } krt_wr_t;

  // Priority chain passed from cell to cell, lowest index first.
  typedef struct packed {
    logic             match_seen;
    logic             free_seen;
    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    krt_rec_t         match_rec;
  } krt_pick_t;

  typedef struct packed {
    krt_status_t status;
    logic [3:0]  slot;
    logic [7:0]  avg_half;
    krt_rec_t    rec;
  } krt_res_t;

endpackage

@@ hdl/krt_ifs.sv @@
// Valid/ready channel interfaces for commands and replies.
interface krt_in_if;
  import krt_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        cmd;
  logic [KEY_W-1:0]  rec_key;
  logic [6:0]        age_in;
  logic [7:0]        sex_in;
  logic [6:0]        grade_a_in;
  logic [6:0]        grade_b_in;
  logic [4:0]        day_in;
  logic [3:0]        month_in;
  logic [13:0]       year_in;

  modport source (output valid, cmd, rec_key, age_in, sex_in, grade_a_in, grade_b_in,
                  day_in, month_in, year_in, input ready);
  modport sink (input valid, cmd, rec_key, age_in, sex_in, grade_a_in, grade_b_in,
                day_in, month_in, year_in, output ready);
endinterface

interface krt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot;
  logic [7:0]  avg_half;
  logic [6:0]  grade_a_out;
  logic [6:0]  grade_b_out;
  logic [6:0]  age_out;
  logic [7:0]  sex_out;
  logic [4:0]  day_out;
  logic [3:0]  month_out;
  logic [13:0] year_out;

  modport source (output valid, status, slot, avg_half, grade_a_out, grade_b_out, age_out,
                  sex_out, day_out, month_out, year_out, input ready);
  modport sink (input valid, status, slot, avg_half, grade_a_out, grade_b_out, age_out,
                sex_out, day_out, month_out, year_out, output ready);
endinterface

@@ hdl/krt_cell.sv @@
// One table slot: valid bit, key and record, with its link in the priority chain.
module krt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          capture,
  input  logic [krt_pkg::KEY_W-1:0]     key_in,
  input  logic [krt_pkg::IDX_W-1:0]     my_idx,
  input  krt_pkg::krt_wr_t              wr,
  input  logic [krt_pkg::KEY_W-1:0]     wr_key,
  input  krt_pkg::krt_rec_t             wr_rec,
  input  logic [6:0]                    wr_grade,
  input  krt_pkg::krt_pick_t            pick_in,
  output krt_pkg::krt_pick_t            pick_out
);
  import krt_pkg::*;

  logic             valid_r;
  logic [KEY_W-1:0] key_r;
  krt_rec_t         rec_r;
  logic             match_r;
  logic             free_r;
  logic             match_first;
  logic             free_first;

  // Compare results are taken when a transaction is accepted; the table does not
  // change again until the commit that uses them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      free_r  <= 1'b0;
    end else if (capture) begin
      match_r <= valid_r && (key_r == key_in);
      free_r  <= !valid_r;
    end
  end

  assign match_first = match_r && !pick_in.match_seen;
  assign free_first  = free_r && !pick_in.free_seen;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.wr_new && free_first) begin
      valid_r <= 1'b1;
    end else if (wr.clr && match_first) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_new && free_first) begin
      key_r <= wr_key;
      rec_r <= wr_rec;
    end else if (wr.set_a && match_first) begin
      rec_r.grade_a <= wr_grade;
    end else if (wr.set_b && match_first) begin
      rec_r.grade_b <= wr_grade;
    end
  end

  always_comb begin
    pick_out = pick_in;
    if (match_first) begin
      pick_out.match_seen = 1'b1;
      pick_out.match_idx  = my_idx;
      pick_out.match_rec  = rec_r;
    end
    if (free_first) begin
      pick_out.free_seen = 1'b1;
      pick_out.free_idx  = my_idx;
    end
  end

endmodule

@@ hdl/keyed_record_table_unit.sv @@
// Top level of the keyed record table: command control, cell row and reply register.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    cmd, rec_key, age_in .. year_in
//   out_ch    out  valid/ready    status, slot, avg_half, grade_a_out .. year_out
//
// At the accept edge each cell latches its key compare and free bit; the commit then
// resolves the lowest matching and free slot along the cell chain, writes the
// winning cell and loads the reply register.
// A reply left waiting in the reply register holds the commit until it is taken.
// Synchronous reset clears all valid bits; keys and records keep no reset.
`include "keyed_record_table_unit_defines.svh"

module keyed_record_table_unit (
  input logic   clk,
  input logic   rst_n,
  krt_in_if.sink    in_ch,
  krt_out_if.source out_ch
);
  import krt_pkg::*;

  krt_state_t       state_r;
  krt_state_t       state_nxt;
  logic             capture;
  logic             commit_go;

  krt_cmd_t         cmd_r;
  logic [KEY_W-1:0] key_r;
  krt_rec_t         new_rec_r;
  logic [6:0]       grade_r;

  krt_pick_t        pick [SLOTS+1];
  krt_wr_t          wr_raw;
  krt_wr_t          wr;
  krt_res_t         res;
  krt_res_t         out_res_r;
  logic             out_valid_r;
  logic [IDX_W-1:0] res_idx;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (capture)   state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    commit_go   = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_COMMIT: commit_go   = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign capture = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      cmd_r     <= krt_cmd_t'(in_ch.cmd);
      key_r     <= in_ch.rec_key;
      grade_r   <= in_ch.grade_a_in;
      new_rec_r <= '{year: in_ch.year_in, month: in_ch.month_in, day: in_ch.day_in,
                     grade_b: in_ch.grade_b_in, grade_a: in_ch.grade_a_in,
                     sex: in_ch.sex_in, age: in_ch.age_in};
    end
  end

  assign pick[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    krt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .capture  (capture),
      .key_in   (in_ch.rec_key),
      .my_idx   (IDX_W'(i)),
      .wr       (wr),
      .wr_key   (key_r),
      .wr_rec   (new_rec_r),
      .wr_grade (grade_r),
      .pick_in  (pick[i]),
      .pick_out (pick[i+1])
    );
  end

  // Command decode on the resolved chain. A full table wins over a duplicate key.
  always_comb begin
    wr_raw     = '0;
    res.status = ST_OK;
    res_idx    = '0;
    res.rec    = '0;
    unique case (cmd_r)
      CMD_INSERT: begin
        if (!pick[SLOTS].free_seen) begin
          res.status = ST_FULL;
        end else if (pick[SLOTS].match_seen) begin
          res.status = ST_DUP;
          res_idx    = pick[SLOTS].match_idx;
          res.rec    = pick[SLOTS].match_rec;
        end else begin
          wr_raw.wr_new = 1'b1;
          res_idx       = pick[SLOTS].free_idx;
          res.rec       = new_rec_r;
        end
      end
      CMD_DELETE, CMD_SET_A, CMD_SET_B: begin
        if (!pick[SLOTS].match_seen) begin
          res.status = ST_MISSING;
        end else begin
          res_idx = pick[SLOTS].match_idx;
          res.rec = pick[SLOTS].match_rec;
          if (cmd_r == CMD_DELETE) begin
            wr_raw.clr = 1'b1;
          end else if (cmd_r == CMD_SET_A) begin
            wr_raw.set_a    = 1'b1;
            res.rec.grade_a = grade_r;
          end else begin
            wr_raw.set_b    = 1'b1;
            res.rec.grade_b = grade_r;
          end
        end
      end
      default: begin
        // Lookup; the unused codes behave the same way.
        if (!pick[SLOTS].match_seen) begin
          res.status = ST_MISSING;
        end else begin
          res_idx = pick[SLOTS].match_idx;
          res.rec = pick[SLOTS].match_rec;
        end
      end
    endcase
    res.slot     = res_idx[3:0];
    res.avg_half = {1'b0, res.rec.grade_a} + {1'b0, res.rec.grade_b};
  end

  assign wr = commit_go ? wr_raw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.slot        = out_res_r.slot;
  assign out_ch.avg_half    = out_res_r.avg_half;
  assign out_ch.grade_a_out = out_res_r.rec.grade_a;
  assign out_ch.grade_b_out = out_res_r.rec.grade_b;
  assign out_ch.age_out     = out_res_r.rec.age;
  assign out_ch.sex_out     = out_res_r.rec.sex;
  assign out_ch.day_out     = out_res_r.rec.day;
  assign out_ch.month_out   = out_res_r.rec.month;
  assign out_ch.year_out    = out_res_r.rec.year;

  `KRT_ASSERT_NEXT(a_full_reported,
    commit_go && (cmd_r == CMD_INSERT) && !pick[SLOTS].free_seen,
    out_res_r.status == ST_FULL, "insert into a full table not reported as full")
  `KRT_ASSERT_NEXT(a_commit_waits,
    (state_r == S_COMMIT) && out_valid_r && !out_ch.ready,
    state_r == S_COMMIT, "commit left while the reply register was still occupied")
  `KRT_ASSERT_NEXT(a_commit_loads,
    commit_go, out_valid_r && (state_r == S_IDLE), "commit did not load a reply")

endmodule
